// ===== hdl/ulst_pkg.sv =====
// Shared codes, state encoding and controller/datapath interface types.
`timescale 1ns / 1ps

package ulst_pkg;

    typedef enum logic [2:0] {
        FUNC_INS_FRONT = 3'd0,
        FUNC_APPEND    = 3'd1,
        FUNC_READ_ALL  = 3'd2,
        FUNC_REMOVE    = 3'd3,
        FUNC_CLEAR     = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_ISSUE,
        S_READ_EMIT,
        S_RM_RUN,
        S_RM_FIN,
        S_REPLY
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    ins_front;
        logic    ins_back;
        logic    clear;
        logic    walk_init;
        logic    rd_issue;
        logic    rm_step;
        logic    rm_finish;
        logic    out_entry;
        logic    out_reply;
        t_status reply_status;
    } t_ulst_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;
        logic walk_end;
        logic rm_idle;
        logic none_removed;
    } t_ulst_sts;

endpackage

// ===== hdl/ulst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ulst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ulst_ctrl.sv =====
// Request sequencer: decodes each item and steps the datapath through it.
`timescale 1ns / 1ps

module ulst_ctrl
    import ulst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic [2:0] i_func,
    output logic      o_in_stall,
    input  t_ulst_sts i_sts,
    output t_ulst_cmd o_cmd
);

    t_state  r_state;
    t_state  n_state;
    t_status r_status;
    t_status n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state            = r_state;
        n_status           = r_status;
        o_cmd              = '0;
        o_cmd.reply_status = r_status;
        o_in_stall         = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_func)
                        FUNC_INS_FRONT, FUNC_APPEND: begin
                            n_state = S_REPLY;
                            if (i_sts.full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status        = ST_OK;
                                o_cmd.ins_front = (i_func == FUNC_INS_FRONT);
                                o_cmd.ins_back  = (i_func == FUNC_APPEND);
                            end
                        end
                        FUNC_READ_ALL: begin
                            if (i_sts.empty) begin
                                n_status = ST_EMPTY;
                                n_state  = S_REPLY;
                            end else begin
                                o_cmd.walk_init = 1'b1;
                                n_state         = S_READ_ISSUE;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (i_sts.empty) begin
                                n_status = ST_EMPTY;
                                n_state  = S_REPLY;
                            end else begin
                                o_cmd.walk_init = 1'b1;
                                n_state         = S_RM_RUN;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_state = S_REPLY;
                            if (i_sts.empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_status    = ST_OK;
                                o_cmd.clear = 1'b1;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ_ISSUE: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_READ_EMIT;
            end
            S_READ_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_entry = 1'b1;
                    n_state         = i_sts.walk_end ? S_IDLE : S_READ_ISSUE;
                end
            end
            S_RM_RUN: begin
                if (i_sts.rm_idle) begin
                    n_state = S_RM_FIN;
                end else begin
                    o_cmd.rm_step = 1'b1;
                end
            end
            S_RM_FIN: begin
                o_cmd.rm_finish = 1'b1;
                n_status        = i_sts.none_removed ? ST_NOT_FOUND : ST_OK;
                n_state         = S_REPLY;
            end
            S_REPLY: begin
                if (i_sts.out_free) begin
                    o_cmd.out_reply = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ulst_dpath.sv =====
// Ring store datapath: pointers, counters, compaction walk and result register.
`timescale 1ns / 1ps

module ulst_dpath
    import ulst_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [31:0] i_value,
    input  t_ulst_cmd          i_cmd,
    output t_ulst_sts          o_sts,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_entry_value,
    output logic [6:0]         o_removed_count,
    output logic               o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int LW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    logic [AW-1:0]         r_front, n_front;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]         r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_kept, n_kept;
    logic                  r_pend, n_pend;
    logic [VALUE_BITS-1:0] r_key, n_key;
    logic [CW-1:0]         r_gone, n_gone;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [31:0]           r_out_entry, n_out_entry;
    logic [CW-1:0]         r_out_removed, n_out_removed;
    logic                  r_out_last, n_out_last;

    logic [VALUE_BITS-1:0] value_in;
    logic [VALUE_BITS-1:0] rdata;
    logic [SW-1:0]         app_sum;
    logic [AW-1:0]         app_slot;
    logic [AW-1:0]         front_dec;
    logic                  idx_end;
    logic                  out_free;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic                  keep_entry;

    assign value_in  = VALUE_BITS'(i_value[LW-1:0]);
    assign app_sum   = {1'b0, r_front} + SW'(r_count);
    assign app_slot  = (app_sum >= SW'(DEPTH)) ? AW'(app_sum - SW'(DEPTH)) : AW'(app_sum);
    assign front_dec = f_dec(r_front);
    assign idx_end   = (r_idx == r_count);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign keep_entry = i_cmd.rm_step && r_pend && (rdata != r_key);

    assign o_sts.empty        = (r_count == '0);
    assign o_sts.full         = (r_count == CW'(DEPTH));
    assign o_sts.out_free     = out_free;
    assign o_sts.walk_end     = idx_end;
    assign o_sts.rm_idle      = idx_end && !r_pend;
    assign o_sts.none_removed = (r_kept == r_count);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wr_ptr;
        mem_wdata = rdata;
        if (i_cmd.ins_front) begin
            mem_we    = 1'b1;
            mem_waddr = front_dec;
            mem_wdata = value_in;
        end else if (i_cmd.ins_back) begin
            mem_we    = 1'b1;
            mem_waddr = app_slot;
            mem_wdata = value_in;
        end else if (keep_entry) begin
            mem_we = 1'b1;
        end
        mem_re = i_cmd.rd_issue || (i_cmd.rm_step && !idx_end);
    end

    ulst_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_front       = r_front;
        n_count       = r_count;
        n_rd_ptr      = r_rd_ptr;
        n_wr_ptr      = r_wr_ptr;
        n_idx         = r_idx;
        n_kept        = r_kept;
        n_pend        = r_pend;
        n_key         = r_key;
        n_gone        = r_gone;
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_entry   = r_out_entry;
        n_out_removed = r_out_removed;
        n_out_last    = r_out_last;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.accept) begin
            n_gone = '0;
        end
        if (i_cmd.ins_front) begin
            n_front = front_dec;
            n_count = r_count + CW'(1);
        end
        if (i_cmd.ins_back) begin
            n_count = r_count + CW'(1);
        end
        if (i_cmd.clear) begin
            n_front = '0;
            n_count = '0;
        end
        if (i_cmd.walk_init) begin
            n_rd_ptr = r_front;
            n_wr_ptr = r_front;
            n_idx    = '0;
            n_kept   = '0;
            n_pend   = 1'b0;
            n_key    = value_in;
        end
        if (i_cmd.rd_issue) begin
            n_rd_ptr = f_inc(r_rd_ptr);
            n_idx    = r_idx + CW'(1);
        end
        if (i_cmd.rm_step) begin
            n_pend = !idx_end;
            if (!idx_end) begin
                n_rd_ptr = f_inc(r_rd_ptr);
                n_idx    = r_idx + CW'(1);
            end
            if (keep_entry) begin
                n_wr_ptr = f_inc(r_wr_ptr);
                n_kept   = r_kept + CW'(1);
            end
        end
        if (i_cmd.rm_finish) begin
            n_count = r_kept;
            n_gone  = r_count - r_kept;
        end
        if (i_cmd.out_entry) begin
            n_out_valid   = 1'b1;
            n_out_status  = ST_OK;
            n_out_entry   = 32'(rdata[LW-1:0]);
            n_out_removed = '0;
            n_out_last    = idx_end;
        end
        if (i_cmd.out_reply) begin
            n_out_valid   = 1'b1;
            n_out_status  = i_cmd.reply_status;
            n_out_entry   = '0;
            n_out_removed = r_gone;
            n_out_last    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_front     <= n_front;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr      <= n_rd_ptr;
        r_wr_ptr      <= n_wr_ptr;
        r_idx         <= n_idx;
        r_kept        <= n_kept;
        r_key         <= n_key;
        r_gone        <= n_gone;
        r_out_status  <= n_out_status;
        r_out_entry   <= n_out_entry;
        r_out_removed <= n_out_removed;
        r_out_last    <= n_out_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_entry_value   = r_out_entry;
    assign o_removed_count = 7'(r_out_removed);
    assign o_last          = r_out_last;

endmodule

// ===== hdl/unordered_list_engine.sv =====
// Top level of the unordered list engine: sequencer plus ring store datapath.
//
//   channel  valid        stall         payload
//   request  i_in_valid   o_in_stall    i_func, i_value
//   result   o_out_valid  i_out_stall   o_status, o_entry_value, o_removed_count, o_last
//
// Insert, append, clear and every empty or full case: accept, then one reply.
// Read all: one RAM read and one result per entry, alternating issue and emit states.
// Remove: the single RAM read port walks the list while
// survivors are written back behind it.
// Reset empties the list at once; stored values need no clearing.
// A stalled result holds the result register and the sequencer waits on it.
`timescale 1ns / 1ps

module unordered_list_engine
    import ulst_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_entry_value,
    output logic [6:0]         o_removed_count,
    output logic               o_last
);

    t_ulst_cmd cmd;
    t_ulst_sts sts;

    ulst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ulst_dpath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_value         (i_value),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_entry_value   (o_entry_value),
        .o_removed_count (o_removed_count),
        .o_last          (o_last)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for unordered_list_engine: predicts each request and checks every result.
`timescale 1ns / 1ps

module tb_top;
    import ulst_pkg::*;

    localparam int LIST_DEPTH   = 64;
    localparam int RANDOM_ITEMS = 40;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 150;
    localparam int IDLE_MAX     = 11;
    localparam int REPORT_MAX   = 100;

    localparam logic [2:0] FUNC_RSVD_5 = 3'd5;
    localparam logic [2:0] FUNC_RSVD_6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD_7 = 3'd7;

    localparam logic [31:0] VALUE_POOL [6] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
        32'hFFFF_FFFF, 32'h0000_0001, 32'h5A5A_A5A5
    };

    typedef struct packed {
        t_status     status;
        logic [31:0] entry;
        logic [6:0]  removed;
        logic        last;
    } t_list_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [2:0]         i_func;
    logic signed [31:0] i_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_status;
    logic signed [31:0] o_entry_value;
    logic [6:0]         o_removed_count;
    logic               o_last;

    logic [31:0]  list_entries[$];
    t_list_result expected_results[$];
    int           error_count   = 0;
    int           cycle_count   = 0;
    int           send_gap_max  = IDLE_MAX;
    int           stall_gap_max = IDLE_MAX;

    unordered_list_engine #(
        .DEPTH      (LIST_DEPTH),
        .VALUE_BITS (32)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_entry_value   (o_entry_value),
        .o_removed_count (o_removed_count),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** unordered_list_engine: FAILED **");
        $finish;
    end

    task automatic report_mismatch(string msg);
        if (error_count < REPORT_MAX) begin
            $display("cycle %0d: %s", cycle_count, msg);
        end
        error_count++;
    endtask

    function automatic void push_result(t_status st, logic [31:0] entry, logic [6:0] removed,
                                        logic last);
        t_list_result r;
        r.status  = st;
        r.entry   = entry;
        r.removed = removed;
        r.last    = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_request(logic [2:0] func, logic [31:0] value);
        logic [31:0] kept[$];
        int          n;
        n = list_entries.size();
        case (func)
            FUNC_INS_FRONT, FUNC_APPEND: begin
                if (n >= LIST_DEPTH) begin
                    push_result(ST_FULL, '0, '0, 1'b1);
                end else begin
                    if (func == FUNC_INS_FRONT) list_entries.push_front(value);
                    else list_entries.push_back(value);
                    push_result(ST_OK, '0, '0, 1'b1);
                end
            end
            FUNC_READ_ALL: begin
                if (n == 0) begin
                    push_result(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        push_result(ST_OK, list_entries[i], '0, i == n - 1);
                    end
                end
            end
            FUNC_REMOVE: begin
                if (n == 0) begin
                    push_result(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    foreach (list_entries[i]) begin
                        if (list_entries[i] != value) kept.push_back(list_entries[i]);
                    end
                    push_result((kept.size() == n) ? ST_NOT_FOUND : ST_OK, '0,
                                7'(n - kept.size()), 1'b1);
                    list_entries = kept;
                end
            end
            FUNC_CLEAR: begin
                if (n == 0) begin
                    push_result(ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    list_entries.delete();
                    push_result(ST_OK, '0, '0, 1'b1);
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_request(logic [2:0] func, logic [31:0] value);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
        predict_request(func, value);
    endtask

    function automatic void choose_idling();
        send_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
        stall_gap_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
    endfunction

    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 3);
        if (sel < 2) return VALUE_POOL[$urandom_range(0, 5)];
        if (sel == 2 && list_entries.size() != 0) begin
            return list_entries[$urandom_range(0, list_entries.size() - 1)];
        end
        return $urandom();
    endfunction

    task automatic test_empty_list();
        send_request(FUNC_READ_ALL, $urandom());
        send_request(FUNC_REMOVE, 32'h0000_0000);
        send_request(FUNC_CLEAR, $urandom());
    endtask

    task automatic test_insert_append();
        send_request(FUNC_INS_FRONT, 32'h7FFF_FFFF);
        send_request(FUNC_INS_FRONT, 32'h8000_0000);
        send_request(FUNC_APPEND, 32'h0000_0000);
        send_request(FUNC_APPEND, 32'hFFFF_FFFF);
        send_request(FUNC_INS_FRONT, 32'h0000_0001);
        send_request(FUNC_READ_ALL, $urandom());
    endtask

    task automatic test_remove_value();
        send_request(FUNC_APPEND, 32'h8000_0000);
        send_request(FUNC_REMOVE, 32'h1234_5678);
        send_request(FUNC_REMOVE, 32'h8000_0000);
        send_request(FUNC_READ_ALL, $urandom());
    endtask

    task automatic test_clear_list();
        send_request(FUNC_CLEAR, $urandom());
        send_request(FUNC_READ_ALL, $urandom());
        send_request(FUNC_APPEND, 32'hFFFF_FFFF);
        send_request(FUNC_READ_ALL, $urandom());
    endtask

    task automatic test_unused_funcs();
        send_request(FUNC_RSVD_5, 32'hFFFF_FFFF);
        send_request(FUNC_RSVD_6, 32'h0000_0000);
        send_request(FUNC_RSVD_7, 32'hFFFF_FFFF);
        send_request(FUNC_READ_ALL, $urandom());
        send_request(FUNC_REMOVE, 32'hFFFF_FFFF);
        send_request(FUNC_REMOVE, 32'hFFFF_FFFF);
    endtask

    task automatic test_full_list();
        logic [31:0] fill_value;
        choose_idling();
        send_request(FUNC_CLEAR, $urandom());
        fill_value = $urandom();
        for (int k = 0; k < LIST_DEPTH; k++) begin
            send_request(k[0] ? FUNC_APPEND : FUNC_INS_FRONT, fill_value);
        end
        send_request(FUNC_INS_FRONT, $urandom());
        send_request(FUNC_APPEND, $urandom());
        send_request(FUNC_READ_ALL, $urandom());
        send_request(FUNC_REMOVE, fill_value);
        send_request(FUNC_READ_ALL, $urandom());
    endtask

    task automatic test_random_mix();
        int          roll;
        logic [2:0]  func;
        logic [31:0] value;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 20 == 0) choose_idling();
            roll = $urandom_range(0, 99);
            if (roll < 28) func = FUNC_INS_FRONT;
            else if (roll < 56) func = FUNC_APPEND;
            else if (roll < 70) func = FUNC_READ_ALL;
            else if (roll < 90) func = FUNC_REMOVE;
            else if (roll < 95) func = FUNC_CLEAR;
            else if (roll < 97) func = FUNC_RSVD_5;
            else if (roll < 99) func = FUNC_RSVD_6;
            else func = FUNC_RSVD_7;
            value = pick_value();
            if (func == FUNC_REMOVE && list_entries.size() != 0 && $urandom_range(0, 2) != 0) begin
                value = list_entries[$urandom_range(0, list_entries.size() - 1)];
            end
            send_request(func, value);
        end
    endtask

    initial begin : result_stall_driver
        int hold;
        i_out_stall <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            hold = $urandom_range(0, stall_gap_max);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result: status %0d entry %h count %0d last %b",
                                          o_status, o_entry_value, o_removed_count, o_last));
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_entry_value !== want.entry)
                    report_mismatch($sformatf("entry_value %h, want %h", o_entry_value, want.entry));
                if (o_removed_count !== want.removed)
                    report_mismatch($sformatf("removed_count %0d, want %0d",
                                              o_removed_count, want.removed));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", o_last, want.last));
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_func     <= FUNC_INS_FRONT;
        i_value    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_insert_append();
        test_remove_value();
        test_clear_list();
        test_unused_funcs();
        test_full_list();
        test_random_mix();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** unordered_list_engine: PASSED **");
        end else begin
            $display("** unordered_list_engine: FAILED **");
        end
        $finish;
    end

endmodule
